// ===== rtl/srcf_pkg.sv =====
// Shared types and constants for the read composition filter.
package srcf_pkg;

    localparam int NSYM         = 6;
    localparam int OUT_LEN_W    = 12;
    localparam int MIN_GOOD_LEN = 12;

    localparam int SYM_A    = 0;
    localparam int SYM_C    = 1;
    localparam int SYM_G    = 2;
    localparam int SYM_T    = 3;
    localparam int SYM_N    = 4;
    localparam int SYM_FOUR = 5;

    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_G    = 8'h47;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_FOUR = 8'h34;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [OUT_LEN_W-1:0] LEN_MASK = {OUT_LEN_W{1'b1}};

    typedef enum logic [2:0] {
        REASON_NONE     = 3'd0,
        REASON_SHORT    = 3'd1,
        REASON_COLOR    = 3'd2,
        REASON_DOMINANT = 3'd3,
        REASON_AMBIG    = 3'd4
    } reason_t;

    typedef struct packed {
        logic [NSYM-1:0] hit;
        logic            is_four;
    } sym_t;

    typedef struct packed {
        logic [31:0]          read_number;
        logic                 read_passed;
        reason_t              reject_reason;
        logic [OUT_LEN_W-1:0] read_length;
        logic [OUT_LEN_W-1:0] shortest_length;
        logic [OUT_LEN_W-1:0] longest_length;
        logic [31:0]          rejected_total;
    } result_t;

endpackage

// ===== rtl/srcf_if.sv =====
// Valid/ready channel interfaces for read characters and read verdicts.
interface srcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       last_base;

    modport source (output valid, output base_char, output last_base, input ready);
    modport sink (input valid, input base_char, input last_base, output ready);
endinterface

interface srcf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_number;
    logic        read_passed;
    logic [2:0]  reject_reason;
    logic [11:0] read_length;
    logic [11:0] shortest_length;
    logic [11:0] longest_length;
    logic [31:0] rejected_total;

    modport source (
        output valid, output read_number, output read_passed, output reject_reason,
        output read_length, output shortest_length, output longest_length,
        output rejected_total, input ready
    );
    modport sink (
        input valid, input read_number, input read_passed, input reject_reason,
        input read_length, input shortest_length, input longest_length,
        input rejected_total, output ready
    );
endinterface

// ===== rtl/srcf_decode.sv =====
// Character folding to upper case and symbol slot decode.
module srcf_decode (
    input  logic [7:0]   base_char,
    output srcf_pkg::sym_t sym
);

    logic [7:0] upper;

    always_comb
    begin
        if (base_char >= srcf_pkg::CHAR_LC_A && base_char <= srcf_pkg::CHAR_LC_Z)
        begin
            upper = base_char - srcf_pkg::CASE_GAP;
        end
        else
        begin
            upper = base_char;
        end
    end

    always_comb
    begin
        sym.hit = '0;
        unique case (upper)
            srcf_pkg::CHAR_A:    sym.hit[srcf_pkg::SYM_A]    = 1'b1;
            srcf_pkg::CHAR_C:    sym.hit[srcf_pkg::SYM_C]    = 1'b1;
            srcf_pkg::CHAR_G:    sym.hit[srcf_pkg::SYM_G]    = 1'b1;
            srcf_pkg::CHAR_T:    sym.hit[srcf_pkg::SYM_T]    = 1'b1;
            srcf_pkg::CHAR_N:    sym.hit[srcf_pkg::SYM_N]    = 1'b1;
            srcf_pkg::CHAR_FOUR: sym.hit[srcf_pkg::SYM_FOUR] = 1'b1;
            default:             sym.hit = '0;
        endcase
        sym.is_four = sym.hit[srcf_pkg::SYM_FOUR];
    end

endmodule

// ===== rtl/srcf_verdict.sv =====
// End-of-read checks: length, color four, dominant base, ambiguous share.
module srcf_verdict #(
    parameter int LEN_W = 12
) (
    input  logic [LEN_W-1:0] sym_count [srcf_pkg::NSYM],
    input  logic [LEN_W-1:0] read_len,
    input  logic             second_is_four,
    input  logic             color_mode,
    output srcf_pkg::reason_t reason
);

    localparam int MUL_W = LEN_W + 4;

    logic [MUL_W-1:0] len_x1;
    logic [MUL_W-1:0] len_x9;
    logic [MUL_W-1:0] cnt_x10 [srcf_pkg::NSYM];
    logic             dominant;
    logic             ambiguous;
    logic             too_short;

    assign len_x1 = MUL_W'(read_len);
    assign len_x9 = (len_x1 << 3) + len_x1;

    always_comb
    begin
        for (int i = 0; i < srcf_pkg::NSYM; i++)
        begin
            cnt_x10[i] = (MUL_W'(sym_count[i]) << 3) + (MUL_W'(sym_count[i]) << 1);
        end
    end

    assign too_short = read_len < LEN_W'(srcf_pkg::MIN_GOOD_LEN);
    assign dominant  = (cnt_x10[srcf_pkg::SYM_A] > len_x9) ||
                       (cnt_x10[srcf_pkg::SYM_C] > len_x9) ||
                       (cnt_x10[srcf_pkg::SYM_G] > len_x9) ||
                       (cnt_x10[srcf_pkg::SYM_T] > len_x9);
    assign ambiguous = (cnt_x10[srcf_pkg::SYM_N] >= len_x1) ||
                       (cnt_x10[srcf_pkg::SYM_FOUR] >= len_x1);

    always_comb
    begin
        if (too_short)
        begin
            reason = srcf_pkg::REASON_SHORT;
        end
        else if (color_mode && second_is_four)
        begin
            reason = srcf_pkg::REASON_COLOR;
        end
        else if (dominant)
        begin
            reason = srcf_pkg::REASON_DOMINANT;
        end
        else if (ambiguous)
        begin
            reason = srcf_pkg::REASON_AMBIG;
        end
        else
        begin
            reason = srcf_pkg::REASON_NONE;
        end
    end

endmodule

// ===== rtl/sequencing_read_composition_filter.sv =====
// Top level of the sequencing read composition filter.
// Takes one read character per cycle; each accepted item passes through an input
// register, then the per-read counters and the end-of-read checks, and on the last
// character a verdict is registered in the output register. Sustained rate
// is one item per cycle, set by the single counter-update stage; the output register
// lets all but the next read's last character stream in while a verdict waits.
module sequencing_read_composition_filter #(
    parameter int LEN_LIMIT = 4095
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    srcf_in_if.sink    seq_in,
    srcf_out_if.source verdict_out
);

    localparam int LEN_W  = $clog2(LEN_LIMIT + 1);
    localparam int STAT_W = (LEN_W > srcf_pkg::OUT_LEN_W) ? LEN_W : srcf_pkg::OUT_LEN_W;
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(LEN_LIMIT);
    localparam logic [STAT_W-1:0] STAT_TOP = STAT_W'(srcf_pkg::LEN_MASK);

    logic             s1_valid_reg;
    logic [7:0]       s1_char_reg;
    logic             s1_last_reg;
    logic             color_mode_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] cnt_reg  [srcf_pkg::NSYM];
    logic [LEN_W-1:0] cnt_next [srcf_pkg::NSYM];
    logic             sif_reg;
    logic             sif_next;
    logic [31:0]      reads_reg;
    logic [31:0]      reads_next;
    logic [31:0]      rejects_reg;
    logic [31:0]      rejects_next;
    logic [STAT_W-1:0] min_reg;
    logic [STAT_W-1:0] min_next;
    logic [STAT_W-1:0] max_reg;
    logic [STAT_W-1:0] max_next;
    logic [STAT_W-1:0] len_stat;
    logic [STAT_W-1:0] cm_stat;
    logic [STAT_W-1:0] shortest;
    logic [STAT_W-1:0] longest;
    logic             out_valid_reg;
    srcf_pkg::result_t out_reg;
    srcf_pkg::result_t out_next;
    srcf_pkg::sym_t    sym;
    srcf_pkg::reason_t reason;
    logic             out_free;
    logic             s1_advance;
    logic             s1_done;
    logic             in_take;

    assign out_free   = !out_valid_reg || verdict_out.ready;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_done    = s1_advance && s1_last_reg;
    assign in_take    = seq_in.valid && seq_in.ready;
    assign seq_in.ready = !s1_valid_reg || s1_advance;

    srcf_decode u_decode (
        .base_char (s1_char_reg),
        .sym       (sym)
    );

    always_comb
    begin
        len_next = (len_reg < LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;
        for (int i = 0; i < srcf_pkg::NSYM; i++)
        begin
            if (sym.hit[i] && cnt_reg[i] < LEN_MAX)
            begin
                cnt_next[i] = cnt_reg[i] + LEN_W'(1);
            end
            else
            begin
                cnt_next[i] = cnt_reg[i];
            end
        end
        sif_next = sif_reg || (len_reg == LEN_W'(1) && sym.is_four);
    end

    srcf_verdict #(
        .LEN_W (LEN_W)
    ) u_verdict (
        .sym_count      (cnt_next),
        .read_len       (len_next),
        .second_is_four (sif_next),
        .color_mode     (color_mode_reg),
        .reason         (reason)
    );

    always_comb
    begin
        len_stat   = STAT_W'(len_next);
        cm_stat    = STAT_W'(color_mode_reg);
        reads_next = reads_reg + 32'd1;
        min_next   = min_reg;
        max_next   = max_reg;
        if (len_next >= LEN_W'(srcf_pkg::MIN_GOOD_LEN))
        begin
            if (len_stat < min_reg)
            begin
                min_next = len_stat;
            end
            if (len_stat > max_reg)
            begin
                max_next = len_stat;
            end
        end
        rejects_next = (reason != srcf_pkg::REASON_NONE) ? rejects_reg + 32'd1 : rejects_reg;
        shortest     = (min_next == STAT_TOP) ? STAT_TOP : min_next - cm_stat;
        longest      = (max_next >= cm_stat) ? max_next - cm_stat : '0;

        out_next.read_number     = reads_next;
        out_next.read_passed     = (reason == srcf_pkg::REASON_NONE);
        out_next.reject_reason   = reason;
        out_next.read_length     = srcf_pkg::OUT_LEN_W'(len_next);
        out_next.shortest_length = shortest[srcf_pkg::OUT_LEN_W-1:0];
        out_next.longest_length  = longest[srcf_pkg::OUT_LEN_W-1:0];
        out_next.rejected_total  = rejects_next;
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (seq_in.ready)
        begin
            s1_valid_reg <= seq_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= seq_in.base_char;
            s1_last_reg <= seq_in.last_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            color_mode_reg <= cfg_wdata;
        end
    end

    // per-read counters; clear on the last item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            sif_reg <= 1'b0;
            for (int i = 0; i < srcf_pkg::NSYM; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                len_reg <= '0;
                sif_reg <= 1'b0;
                for (int i = 0; i < srcf_pkg::NSYM; i++)
                begin
                    cnt_reg[i] <= '0;
                end
            end
            else
            begin
                len_reg <= len_next;
                sif_reg <= sif_next;
                for (int i = 0; i < srcf_pkg::NSYM; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
        end
    end

    // running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_reg   <= '0;
            rejects_reg <= '0;
            min_reg     <= STAT_TOP;
            max_reg     <= '0;
        end
        else if (s1_done)
        begin
            reads_reg   <= reads_next;
            rejects_reg <= rejects_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            out_reg <= out_next;
        end
    end

    assign verdict_out.valid           = out_valid_reg;
    assign verdict_out.read_number     = out_reg.read_number;
    assign verdict_out.read_passed     = out_reg.read_passed;
    assign verdict_out.reject_reason   = out_reg.reject_reason;
    assign verdict_out.read_length     = out_reg.read_length;
    assign verdict_out.shortest_length = out_reg.shortest_length;
    assign verdict_out.longest_length  = out_reg.longest_length;
    assign verdict_out.rejected_total  = out_reg.rejected_total;

    a_pass_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_reg.read_passed == (out_reg.reject_reason == srcf_pkg::REASON_NONE)))
        else $error("pass flag disagrees with reject reason");

    a_mid_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !s1_last_reg) |=> $stable(reads_reg) && $stable(rejects_reg))
        else $error("read counters moved on a mid-read item");

    a_clear_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done |=> (len_reg == '0) && !sif_reg)
        else $error("per-read state not cleared after last item");

endmodule
